>>> rtl/dab_pkg.sv
// ----------------------------------------------------------------------------
// DNS answer builder package
// Shared constants, operation codes, the job record passed to the output
// serializer and the answer record byte lookup.
// ----------------------------------------------------------------------------
package dab_pkg;

    // Answer table size and derived widths.
    localparam int MAX_ANSWERS = 16;
    localparam int IDX_W       = (MAX_ANSWERS > 1) ? $clog2(MAX_ANSWERS) : 1;
    localparam int CNT_W       = $clog2(MAX_ANSWERS + 1);

    // Query byte offset counter, saturating at its all-ones value.
    localparam int                OFS_W   = 9;
    localparam logic [OFS_W-1:0]  OFS_MAX = '1;

    // Header byte positions that are rewritten.
    localparam logic [OFS_W-1:0] OFS_FLAGS_HI = OFS_W'(2);
    localparam logic [OFS_W-1:0] OFS_FLAGS_LO = OFS_W'(3);
    localparam logic [OFS_W-1:0] OFS_ANCNT_HI = OFS_W'(6);
    localparam logic [OFS_W-1:0] OFS_ANCNT_LO = OFS_W'(7);

    // Operation codes.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_EMIT  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Response flag bytes.
    localparam logic [7:0] FLAGS_HI       = 8'h81;
    localparam logic [7:0] RCODE_NXDOMAIN = 8'h83;
    localparam logic [7:0] RCODE_OK       = 8'h80;

    // Answer record fields.
    localparam logic [15:0] NAME_PTR  = 16'hC00C;
    localparam logic [15:0] TYPE_A    = 16'h0001;
    localparam logic [15:0] CLASS_IN  = 16'h0001;
    localparam logic [31:0] TTL_VALUE = 32'h000000B0;
    localparam logic [15:0] RDLENGTH  = 16'h0004;

    // Record byte index.
    localparam int               REC_W    = 4;
    localparam logic [REC_W-1:0] REC_LAST = '1;

    // One pending output job: a single query byte or a whole answer record.
    typedef struct packed {
        logic        is_record;
        logic [7:0]  data;
        logic [31:0] addr;
        logic        msg_end;
    } job_t;

    // Byte k of an answer record carrying address a.
    function automatic logic [7:0] rec_byte(input logic [REC_W-1:0] k,
                                            input logic [31:0] a);
        logic [7:0] b;
        unique case (k)
            4'd0:    b = NAME_PTR[15:8];
            4'd1:    b = NAME_PTR[7:0];
            4'd2:    b = TYPE_A[15:8];
            4'd3:    b = TYPE_A[7:0];
            4'd4:    b = CLASS_IN[15:8];
            4'd5:    b = CLASS_IN[7:0];
            4'd6:    b = TTL_VALUE[31:24];
            4'd7:    b = TTL_VALUE[23:16];
            4'd8:    b = TTL_VALUE[15:8];
            4'd9:    b = TTL_VALUE[7:0];
            4'd10:   b = RDLENGTH[15:8];
            4'd11:   b = RDLENGTH[7:0];
            4'd12:   b = a[31:24];
            4'd13:   b = a[23:16];
            4'd14:   b = a[15:8];
            4'd15:   b = a[7:0];
        endcase
        return b;
    endfunction

endpackage

>>> rtl/dab_ctrl.sv
// ----------------------------------------------------------------------------
// DNS answer builder control
// Holds the answer table and transaction state, decodes each accepted item
// and registers the resulting output job.
// ----------------------------------------------------------------------------
module dab_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  logic [1:0]     operation,
    input  logic [7:0]     query_byte,
    input  logic           is_last,
    input  logic [31:0]    address,
    input  logic           job_take,
    output logic           job_valid,
    output dab_pkg::job_t  job
);
    import dab_pkg::*;

    logic [31:0]      table_mem [MAX_ANSWERS];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] ptr_inc;
    logic [OFS_W-1:0] ofs_reg, ofs_next;
    logic             job_valid_reg, job_valid_next;
    job_t             job_reg, job_new;
    logic             job_gen;
    logic             accept;
    logic             blocked;
    logic             table_wr;
    logic [7:0]       count_byte;

    assign item_stall = job_valid_reg && !job_take;
    assign accept     = item_valid && !item_stall;
    assign blocked    = (count_reg == '0) || (table_mem[0] == 32'd0);
    assign ptr_inc    = ptr_reg + CNT_W'(1);
    assign count_byte = 8'(count_reg);

    always_comb
    begin
        count_next = count_reg;
        ptr_next   = ptr_reg;
        ofs_next   = ofs_reg;
        table_wr   = 1'b0;
        job_gen    = 1'b0;
        job_new    = '{is_record: 1'b0, data: query_byte, addr: address, msg_end: 1'b0};
        if (accept)
        begin
            unique case (operation)
                OP_LOAD:
                begin
                    if (count_reg < CNT_W'(MAX_ANSWERS))
                    begin
                        table_wr   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_QUERY:
                begin
                    job_gen = 1'b1;
                    priority if (ofs_reg == OFS_FLAGS_HI)
                        job_new.data = FLAGS_HI;
                    else if (ofs_reg == OFS_FLAGS_LO)
                        job_new.data = blocked ? RCODE_NXDOMAIN : RCODE_OK;
                    else if (ofs_reg == OFS_ANCNT_HI)
                        job_new.data = 8'h00;
                    else if (ofs_reg == OFS_ANCNT_LO)
                        job_new.data = blocked ? 8'h00 : count_byte;
                    else
                        job_new.data = query_byte;
                    if (is_last)
                    begin
                        ofs_next = '0;
                        if (blocked)
                        begin
                            job_new.msg_end = 1'b1;
                            count_next      = '0;
                            ptr_next        = '0;
                        end
                    end
                    else if (ofs_reg != OFS_MAX)
                    begin
                        ofs_next = ofs_reg + OFS_W'(1);
                    end
                end
                OP_EMIT:
                begin
                    if (!blocked && (ptr_reg < count_reg))
                    begin
                        job_gen           = 1'b1;
                        job_new.is_record = 1'b1;
                        job_new.addr      = table_mem[ptr_reg[IDX_W-1:0]];
                        if (ptr_inc == count_reg)
                        begin
                            job_new.msg_end = 1'b1;
                            count_next      = '0;
                            ptr_next        = '0;
                        end
                        else
                        begin
                            ptr_next = ptr_inc;
                        end
                    end
                end
                OP_NONE:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (accept && job_gen)
            job_valid_next = 1'b1;
        else if (job_take)
            job_valid_next = 1'b0;
        else
            job_valid_next = job_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            ofs_reg       <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            ofs_reg       <= ofs_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (table_wr)
            table_mem[count_reg[IDX_W-1:0]] <= address;
        if (accept && job_gen)
            job_reg <= job_new;
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

>>> rtl/dab_serializer.sv
// ----------------------------------------------------------------------------
// DNS answer builder output serializer
// Result register that sends a query byte as one transaction or an answer
// record as sixteen transactions.
// ----------------------------------------------------------------------------
module dab_serializer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    input  dab_pkg::job_t  job,
    output logic           job_take,
    output logic           result_valid,
    input  logic           result_stall,
    output logic [7:0]     out_byte,
    output logic           run_last,
    output logic           message_end
);
    import dab_pkg::*;

    logic             busy_reg, busy_next;
    logic [REC_W-1:0] idx_reg, idx_next;
    job_t             cur_reg;
    logic             last_beat;
    logic             done;

    assign last_beat = !cur_reg.is_record || (idx_reg == REC_LAST);
    assign done      = busy_reg && !result_stall && last_beat;
    assign job_take  = !busy_reg || done;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (job_take)
        begin
            busy_next = job_valid;
            idx_next  = '0;
        end
        else if (busy_reg && !result_stall)
        begin
            idx_next = idx_reg + REC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take && job_valid)
            cur_reg <= job;
    end

    assign result_valid = busy_reg;
    assign out_byte     = cur_reg.is_record ? rec_byte(idx_reg, cur_reg.addr) : cur_reg.data;
    assign run_last     = last_beat;
    assign message_end  = cur_reg.msg_end && last_beat;

endmodule

>>> rtl/dns_answer_builder.sv
// An accepted item's job is registered in the control stage and then in the serializer's
// result register, which offers it on the output. Throughput: load and query items are
// taken one per cycle unless item_stall is high; an emit item holds the output register
// for its sixteen record bytes, one record byte per cycle unless result_stall is high.
// Reset: rst_n (asynchronous, active low) clears the answer count, emit pointer,
// byte offset and all valid flags; the answer table itself is not cleared.
// ----------------------------------------------------------------------------
// DNS answer builder
// Builds an A-record response from a received query: address transactions
// fill the answer table, query bytes are echoed with the header flags and
// answer count rewritten, and each emit transaction produces one 16-byte
// answer record while an unsent answer remains and the first entry is nonzero.
// ----------------------------------------------------------------------------
module dns_answer_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  query_byte,
    input  logic        is_last,
    input  logic [31:0] address,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        message_end
);
    import dab_pkg::*;

    // The control stage updates the transaction state in the cycle a
    // transaction is accepted and registers at most one job. The serializer holds the
    // job being sent, so the control stage can take the next transaction
    // while a result still waits downstream.
    logic job_valid;
    logic job_take;
    job_t job;

    dab_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .operation  (operation),
        .query_byte (query_byte),
        .is_last    (is_last),
        .address    (address),
        .job_take   (job_take),
        .job_valid  (job_valid),
        .job        (job)
    );

    // Each query byte leaves as one transaction; a record leaves as sixteen,
    // with run_last on the final byte and message_end where the response ends.
    dab_serializer u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (job),
        .job_take     (job_take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .message_end  (message_end)
    );

endmodule

>>> rtl/dab_checker.sv
// ----------------------------------------------------------------------------
// DNS answer builder port checker
// Concurrent checks on the top level's ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module dab_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_stall,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       message_end
);

    // A stalled result holds its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(out_byte))
    else $error("stalled result changed");

    // The response ends only on the final byte of a transaction's results.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && message_end |-> run_last)
    else $error("message_end without run_last");

    // A record streams without gaps: a taken inner byte is followed by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !run_last |=> result_valid)
    else $error("gap inside a record");

    // The input side stalls only while a result is occupying the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
    else $error("input stalled with empty output");

endmodule

bind dns_answer_builder dab_checker u_dab_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .message_end  (message_end)
);
